// ----- src/dhoat_pkg.sv -----
// Shared constants, types and helpers for the double-hash table.
package dhoat_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int SIZE_W    = 11;
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = 64 / MOD_BITS;
    localparam int CNT_W     = $clog2(MOD_STEPS);

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1021;
    localparam logic [31:0]       GOLD_MUL   = 32'd2654435761;
    localparam logic [31:0]       RSV_KEY    = 32'h80000001;

    localparam logic [1:0] CMD_GET = 2'd0;
    localparam logic [1:0] CMD_SET = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam logic [2:0] RES_FOUND = 3'd0;
    localparam logic [2:0] RES_INS   = 3'd1;
    localparam logic [2:0] RES_MISS  = 3'd2;
    localparam logic [2:0] RES_FULL  = 3'd3;
    localparam logic [2:0] RES_RSV   = 3'd4;

    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_USED  = 2'd1;
    localparam logic [1:0] SLOT_FREED = 2'd2;

    typedef struct packed {
        logic [1:0]       command;
        logic [31:0]      key;
        logic [31:0]      value;
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] step;
    } job_t;

    // effective size: at least 2, at most MAX_SLOTS
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        begin
            r = s;
            if (s < SIZE_W'(2))
            begin
                r = SIZE_W'(2);
            end
            else if (s > SIZE_W'(MAX_SLOTS))
            begin
                r = SIZE_W'(MAX_SLOTS);
            end
            return r;
        end
    endfunction

endpackage

// ----- src/dhoat_front.sv -----
// Front end: takes request words, hashes the key and reduces base and step modulo size.
module dhoat_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      command,
    input  logic [31:0]                     key,
    input  logic [31:0]                     value,
    input  logic [dhoat_pkg::SIZE_W-1:0]    cur_size,
    input  logic                            hold,
    output dhoat_pkg::job_t                 job,
    output logic                            job_valid,
    input  logic                            job_ready
);

    typedef enum logic [3:0] {
        FS_IDLE = 4'b0001,
        FS_MUL  = 4'b0010,
        FS_DIV  = 4'b0100,
        FS_PUSH = 4'b1000
    } fstate_t;

    localparam int IW = dhoat_pkg::IDX_W;
    localparam int SW = dhoat_pkg::SIZE_W;

    fstate_t state_reg, state_next;
    logic [1:0]  cmd_reg;
    logic [31:0] key_reg, val_reg;
    logic [63:0] diva_reg, diva_next, divb_reg, divb_next;
    logic [IW-1:0] rema_reg, rema_next, remb_reg, remb_next;
    logic [dhoat_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] div_a, div_b;

    function automatic logic [IW-1:0] mod_step(input logic [IW-1:0] r, input logic b,
                                               input logic [SW-1:0] d);
        logic [IW:0] t;
        begin
            t = {r, b};
            if (t >= d)
            begin
                t = t - d;
            end
            return t[IW-1:0];
        end
    endfunction

    assign div_a = cur_size;
    assign div_b = cur_size - SW'(1);

    assign in_ready  = (state_reg == FS_IDLE) && !hold;
    assign job_valid = (state_reg == FS_PUSH);
    assign job.command = cmd_reg;
    assign job.key     = key_reg;
    assign job.value   = val_reg;
    assign job.base    = rema_reg;
    assign job.step    = remb_reg + IW'(1);

    always_comb
    begin
        state_next = state_reg;
        diva_next  = diva_reg;
        divb_next  = divb_reg;
        rema_next  = rema_reg;
        remb_next  = remb_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            FS_IDLE:
            begin
                if (in_valid && !hold)
                begin
                    state_next = FS_MUL;
                end
            end
            FS_MUL:
            begin
                diva_next  = 64'(key_reg) * 64'(dhoat_pkg::GOLD_MUL);
                divb_next  = (64'(key_reg) << 6) + (64'(key_reg) << 16);
                rema_next  = '0;
                remb_next  = '0;
                cnt_next   = '1;
                state_next = FS_DIV;
            end
            FS_DIV:
            begin
                // a few remainder bits per cycle, MSB first
                for (int i = 0; i < dhoat_pkg::MOD_BITS; i++)
                begin
                    rema_next = mod_step(rema_next, diva_next[63], div_a);
                    remb_next = mod_step(remb_next, divb_next[63], div_b);
                    diva_next = diva_next << 1;
                    divb_next = divb_next << 1;
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = FS_PUSH;
                end
            end
            FS_PUSH:
            begin
                if (job_ready)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg <= command;
            key_reg <= key;
            val_reg <= value;
        end
        diva_reg <= diva_next;
        divb_reg <= divb_next;
        rema_reg <= rema_next;
        remb_reg <= remb_next;
    end

endmodule

// ----- src/dhoat_queue.sv -----
// Two-entry queue of hashed requests between front and back.
module dhoat_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  dhoat_pkg::job_t  push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output dhoat_pkg::job_t  pop_data
);

    dhoat_pkg::job_t slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = slot_reg[rp_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg] <= push_data;
        end
    end

endmodule

// ----- src/dhoat_back.sv -----
// Back end: probe engine over slot memory, counts, clearing sweep and result register.
module dhoat_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dhoat_pkg::SIZE_W-1:0]  cfg_data,
    input  dhoat_pkg::job_t               job,
    input  logic                          job_valid,
    output logic                          job_ready,
    output logic [dhoat_pkg::SIZE_W-1:0]  cur_size,
    output logic                          clearing,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic [31:0]                   value_out,
    output logic [dhoat_pkg::IDX_W-1:0]   probe_count,
    output logic [dhoat_pkg::SIZE_W-1:0]  empty_slots,
    output logic [dhoat_pkg::SIZE_W-1:0]  freed_slots
);

    localparam int IW = dhoat_pkg::IDX_W;
    localparam int SW = dhoat_pkg::SIZE_W;
    localparam int MW = 66;

    typedef enum logic [5:0] {
        BS_CLEAR = 6'b000001,
        BS_IDLE  = 6'b000010,
        BS_RD    = 6'b000100,
        BS_EV    = 6'b001000,
        BS_WR2   = 6'b010000,
        BS_FIN   = 6'b100000
    } bstate_t;

    bstate_t state_reg, state_next;
    logic [SW-1:0] size_reg, size_next, empty_reg, empty_next, freed_reg, freed_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [31:0]   key_reg, key_next, val_reg, val_next, nv_reg, nv_next;
    logic [IW-1:0] step_reg, step_next, idx_reg, idx_next;
    logic [SW-1:0] try_reg, try_next;
    logic          tv_reg, tv_next;
    logic [IW-1:0] tomb_reg, tomb_next, tt_reg, tt_next;
    logic [2:0]    rs_reg, rs_next;
    logic [31:0]   rv_reg, rv_next;
    logic [IW-1:0] rp_reg, rp_next;
    logic          ov_reg, ov_next;
    logic [2:0]    os_reg, os_next;
    logic [31:0]   ovl_reg, ovl_next;
    logic [IW-1:0] opc_reg, opc_next;
    logic [SW-1:0] oe_reg, oe_next, of_reg, of_next;

    logic [MW-1:0] mem [dhoat_pkg::MAX_SLOTS];
    logic [MW-1:0] rd_reg, wd;
    logic [IW-1:0] wa;
    logic          we;

    logic [1:0]    m_st;
    logic [31:0]   m_key, m_val, nv;
    logic [IW:0]   adv_sum;
    logic [IW-1:0] adv;
    logic [SW-1:0] try_inc;
    logic          tv;
    logic [IW-1:0] ti, tt;

    assign m_st  = rd_reg[65:64];
    assign m_key = rd_reg[63:32];
    assign m_val = rd_reg[31:0];

    assign cur_size    = size_reg;
    assign clearing    = (state_reg == BS_CLEAR);
    assign job_ready   = (state_reg == BS_IDLE);
    assign out_valid   = ov_reg;
    assign status      = os_reg;
    assign value_out   = ovl_reg;
    assign probe_count = opc_reg;
    assign empty_slots = oe_reg;
    assign freed_slots = of_reg;

    always_comb
    begin
        adv_sum = {1'b0, idx_reg} + {1'b0, step_reg};
        if (adv_sum >= size_reg)
        begin
            adv_sum = adv_sum - size_reg;
        end
        adv     = adv_sum[IW-1:0];
        try_inc = try_reg + SW'(1);
        // first tombstone, counting the slot under test
        tv = tv_reg || (m_st == dhoat_pkg::SLOT_FREED);
        ti = tv_reg ? tomb_reg : idx_reg;
        tt = tv_reg ? tt_reg : try_reg[IW-1:0];
        nv = (cmd_reg == dhoat_pkg::CMD_SET) ? val_reg : m_val;
    end

    always_comb
    begin
        state_next = state_reg;
        size_next  = size_reg;
        empty_next = empty_reg;
        freed_next = freed_reg;
        clr_next   = clr_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        nv_next    = nv_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        try_next   = try_reg;
        tv_next    = tv_reg;
        tomb_next  = tomb_reg;
        tt_next    = tt_reg;
        rs_next    = rs_reg;
        rv_next    = rv_reg;
        rp_next    = rp_reg;
        ov_next    = ov_reg && !out_ready;
        os_next    = os_reg;
        ovl_next   = ovl_reg;
        opc_next   = opc_reg;
        oe_next    = oe_reg;
        of_next    = of_reg;
        we         = 1'b0;
        wa         = idx_reg;
        wd         = {dhoat_pkg::SLOT_USED, key_reg, val_reg};

        case (state_reg)
            BS_CLEAR:
            begin
                we       = 1'b1;
                wa       = clr_reg;
                wd       = {dhoat_pkg::SLOT_EMPTY, 64'd0};
                clr_next = clr_reg + IW'(1);
                if (clr_reg == IW'(dhoat_pkg::MAX_SLOTS - 1))
                begin
                    state_next = BS_IDLE;
                end
            end
            BS_IDLE:
            begin
                if (job_valid)
                begin
                    cmd_next  = job.command;
                    key_next  = job.key;
                    val_next  = job.value;
                    step_next = job.step;
                    idx_next  = job.base;
                    try_next  = '0;
                    tv_next   = 1'b0;
                    rs_next   = dhoat_pkg::RES_MISS;
                    rv_next   = '0;
                    rp_next   = '0;
                    if (job.command == dhoat_pkg::CMD_SET &&
                        (job.key == 32'd0 || job.key == dhoat_pkg::RSV_KEY))
                    begin
                        rs_next    = dhoat_pkg::RES_RSV;
                        state_next = BS_FIN;
                    end
                    else if (job.command == dhoat_pkg::CMD_NOP)
                    begin
                        state_next = BS_FIN;
                    end
                    else
                    begin
                        state_next = BS_RD;
                    end
                end
            end
            BS_RD:
            begin
                state_next = BS_EV;
            end
            BS_EV:
            begin
                state_next = BS_FIN;
                if (m_st == dhoat_pkg::SLOT_EMPTY)
                begin
                    if (cmd_reg == dhoat_pkg::CMD_SET)
                    begin
                        we      = 1'b1;
                        rs_next = dhoat_pkg::RES_INS;
                        if (tv_reg)
                        begin
                            wa         = tomb_reg;
                            rp_next    = tt_reg;
                            freed_next = freed_reg - SW'(1);
                        end
                        else
                        begin
                            rp_next    = try_reg[IW-1:0];
                            empty_next = empty_reg - SW'(1);
                        end
                    end
                end
                else if (m_st == dhoat_pkg::SLOT_USED && m_key == key_reg)
                begin
                    rs_next = dhoat_pkg::RES_FOUND;
                    rp_next = try_reg[IW-1:0];
                    we      = 1'b1;
                    if (cmd_reg == dhoat_pkg::CMD_DEL)
                    begin
                        rv_next    = m_val;
                        wd         = {dhoat_pkg::SLOT_FREED, key_reg, 32'd0};
                        freed_next = freed_reg + SW'(1);
                    end
                    else
                    begin
                        if (cmd_reg == dhoat_pkg::CMD_GET)
                        begin
                            rv_next = nv;
                        end
                        if (tv_reg)
                        begin
                            // move entry into the first tombstone on the path
                            wd         = {dhoat_pkg::SLOT_FREED, key_reg, nv};
                            nv_next    = nv;
                            state_next = BS_WR2;
                        end
                        else
                        begin
                            wd = {dhoat_pkg::SLOT_USED, key_reg, nv};
                        end
                    end
                end
                else
                begin
                    tv_next   = tv;
                    tomb_next = ti;
                    tt_next   = tt;
                    if (try_inc == size_reg)
                    begin
                        // whole path walked
                        if (cmd_reg == dhoat_pkg::CMD_SET)
                        begin
                            if (tv)
                            begin
                                we         = 1'b1;
                                wa         = ti;
                                rp_next    = tt;
                                rs_next    = dhoat_pkg::RES_INS;
                                freed_next = freed_reg - SW'(1);
                            end
                            else
                            begin
                                rs_next = dhoat_pkg::RES_FULL;
                            end
                        end
                    end
                    else
                    begin
                        idx_next   = adv;
                        try_next   = try_inc;
                        state_next = BS_RD;
                    end
                end
            end
            BS_WR2:
            begin
                we         = 1'b1;
                wa         = tomb_reg;
                wd         = {dhoat_pkg::SLOT_USED, key_reg, nv_reg};
                state_next = BS_FIN;
            end
            BS_FIN:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    os_next    = rs_reg;
                    ovl_next   = rv_reg;
                    opc_next   = rp_reg;
                    oe_next    = empty_reg;
                    of_next    = freed_reg;
                    state_next = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_CLEAR;
            end
        endcase

        if (cfg_we)
        begin
            size_next  = dhoat_pkg::clamp_size(cfg_data);
            empty_next = dhoat_pkg::clamp_size(cfg_data);
            freed_next = '0;
            clr_next   = '0;
            state_next = BS_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_CLEAR;
            size_reg  <= dhoat_pkg::SIZE_RESET;
            empty_reg <= dhoat_pkg::SIZE_RESET;
            freed_reg <= '0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            empty_reg <= empty_next;
            freed_reg <= freed_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        key_reg  <= key_next;
        val_reg  <= val_next;
        nv_reg   <= nv_next;
        step_reg <= step_next;
        idx_reg  <= idx_next;
        try_reg  <= try_next;
        tv_reg   <= tv_next;
        tomb_reg <= tomb_next;
        tt_reg   <= tt_next;
        rs_reg   <= rs_next;
        rv_reg   <= rv_next;
        rp_reg   <= rp_next;
        os_reg   <= os_next;
        ovl_reg  <= ovl_next;
        opc_reg  <= opc_next;
        oe_reg   <= oe_next;
        of_reg   <= of_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_reg <= mem[idx_reg];
    end

endmodule

// ----- src/double_hash_open_address_table_unit.sv -----
// Top level of the double-hash open-addressing key-value table.
// Request words (command, key, value) enter on in_valid/in_ready; one result
// word (status, value_out, probe_count, empty_slots, freed_slots) leaves on
// out_valid/out_ready for every request, in order.
// The front end hashes the key: the MUL state forms the product, the DIV state
// runs 4-bit remainder steps for base and step modulo size, and the PUSH state
// pushes into a two-entry queue. The back end picks up a request in IDLE, takes
// RD then EV per probe on the slot memory (registered read, then compare), WR2
// for a tombstone move, and FIN to load the result register.
// The front end takes a new word only once it has pushed the previous one, but
// the queue lets a request be hashed while the previous one is still probing.
// Reset, and every write of table_size (cfg_we/cfg_data), start a sweep over
// all 1024 slot entries that marks each one empty; in_ready stays low meanwhile.
// A held result parks the back end on its last state; the front end keeps
// hashing until the queue fills, then in_ready stays low.
module double_hash_open_address_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [31:0] key,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] value_out,
    output logic [9:0]  probe_count,
    output logic [10:0] empty_slots,
    output logic [10:0] freed_slots
);

    dhoat_pkg::job_t f_job, q_job;
    logic f_valid, f_ready, q_valid, q_ready, clearing;
    logic [dhoat_pkg::SIZE_W-1:0] cur_size;

    dhoat_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .key       (key),
        .value     (value),
        .cur_size  (cur_size),
        .hold      (clearing),
        .job       (f_job),
        .job_valid (f_valid),
        .job_ready (f_ready)
    );

    dhoat_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_job)
    );

    dhoat_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .job         (q_job),
        .job_valid   (q_valid),
        .job_ready   (q_ready),
        .cur_size    (cur_size),
        .clearing    (clearing),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .value_out   (value_out),
        .probe_count (probe_count),
        .empty_slots (empty_slots),
        .freed_slots (freed_slots)
    );

endmodule

// ----- test/tb.sv -----
// Self-checking bench for the double-hash table: directed rows, then random traffic.
module tb;
    import dhoat_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = CMD_GET;
    logic [31:0] key = '0;
    logic [31:0] value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [31:0] value_out;
    logic [9:0]  probe_count;
    logic [10:0] empty_slots;
    logic [10:0] freed_slots;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value_out;
        logic [9:0]  probe_count;
        logic [10:0] empty_slots;
        logic [10:0] freed_slots;
    } answer_t;

    typedef struct {
        logic [1:0]  command;
        logic [31:0] key;
        logic [31:0] value;
        bit          typed;
        answer_t     answer;
    } row_t;

    answer_t answer_q[$];
    int      fail_cnt = 0;
    int      stall_cnt = 0;
    bit      calm = 1'b0;
    bit      timed_out = 1'b0;

    // predictor state
    logic [1:0]  tbl_state[MAX_SLOTS];
    logic [31:0] tbl_key[MAX_SLOTS];
    logic [31:0] tbl_val[MAX_SLOTS];
    int unsigned tbl_size;
    int unsigned n_empty;
    int unsigned n_freed;
    logic [31:0] live_keys[$];

    double_hash_open_address_table_unit u_dut (.*);

    always #10 clk = ~clk;

    function automatic void clear_table(input logic [10:0] sz);
        tbl_size = (sz < 2) ? 2 : (sz > MAX_SLOTS) ? MAX_SLOTS : sz;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            tbl_state[i] = SLOT_EMPTY;
            tbl_key[i] = '0;
            tbl_val[i] = '0;
        end
        n_empty = tbl_size;
        n_freed = 0;
    endfunction

    function automatic answer_t apply_request(input logic [1:0] cmd, input logic [31:0] k,
                                              input logic [31:0] v);
        logic [127:0] h1, h2, base, stride, s;
        answer_t a;
        bit have_tomb, done;
        int unsigned tomb, tomb_try, t;
        logic [31:0] nv;
        h1 = 128'(k) * 128'(GOLD_MUL);
        h2 = (128'(k) << 6) + (128'(k) << 16);
        base = h1 % tbl_size;
        stride = h2 % (tbl_size - 1) + 1;
        a = '0;
        a.status = RES_MISS;
        have_tomb = 0; done = 0; tomb = 0; tomb_try = 0;
        if (cmd == CMD_SET && (k == 0 || k == RSV_KEY))
        begin
            a.status = RES_RSV;
            done = 1;
        end
        if (cmd == CMD_NOP)
            done = 1;
        for (t = 0; !done && t < tbl_size; t++)
        begin
            s = (base + 128'(t) * stride) % tbl_size;
            if (tbl_state[s] == SLOT_FREED)
            begin
                if (!have_tomb)
                begin
                    have_tomb = 1; tomb = s; tomb_try = t;
                end
                continue;
            end
            if (tbl_state[s] == SLOT_EMPTY)
            begin
                if (cmd == CMD_SET)
                begin
                    if (have_tomb)
                    begin
                        s = tomb; a.probe_count = 10'(tomb_try); n_freed--;
                    end
                    else
                    begin
                        a.probe_count = 10'(t); n_empty--;
                    end
                    tbl_state[s] = SLOT_USED;
                    tbl_key[s] = k;
                    tbl_val[s] = v;
                    a.status = RES_INS;
                    live_keys.push_back(k);
                end
                done = 1;
                break;
            end
            if (tbl_key[s] != k)
                continue;
            done = 1;
            a.status = RES_FOUND;
            a.probe_count = 10'(t);
            if (cmd == CMD_DEL)
            begin
                a.value_out = tbl_val[s];
                tbl_state[s] = SLOT_FREED;
                tbl_val[s] = '0;
                n_freed++;
            end
            else
            begin
                nv = (cmd == CMD_SET) ? v : tbl_val[s];
                if (cmd == CMD_GET)
                    a.value_out = nv;
                if (have_tomb)
                begin
                    tbl_state[s] = SLOT_FREED;
                    tbl_state[tomb] = SLOT_USED;
                    tbl_key[tomb] = k;
                    tbl_val[tomb] = nv;
                end
                else
                    tbl_val[s] = nv;
            end
            break;
        end
        if (!done && cmd == CMD_SET)
        begin
            if (have_tomb)
            begin
                tbl_state[tomb] = SLOT_USED;
                tbl_key[tomb] = k;
                tbl_val[tomb] = v;
                n_freed--;
                a.probe_count = 10'(tomb_try);
                a.status = RES_INS;
                live_keys.push_back(k);
            end
            else
                a.status = RES_FULL;
        end
        a.empty_slots = 11'(n_empty);
        a.freed_slots = 11'(n_freed);
        return a;
    endfunction

    // sender: holds the word until accepted; valid drops only while idling
    task automatic send_word(input logic [1:0] cmd, input logic [31:0] k, input logic [31:0] v);
        while (!calm && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        key <= k;
        value <= v;
        answer_q.push_back(apply_request(cmd, k, v));
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_size(input logic [10:0] sz);
        wait_drain();
        cfg_we <= 1'b1;
        cfg_data <= sz;
        @(posedge clk);
        cfg_we <= 1'b0;
        clear_table(sz);
        live_keys.delete();
    endtask

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 55 && live_keys.size() != 0)
            return live_keys[$urandom_range(live_keys.size() - 1)];
        if (r < 60)
            return (r & 1) ? RSV_KEY : 32'h0;
        if (r < 85)
            return $urandom_range(40, 1);
        return $urandom;
    endfunction

    // receiver: random stalls, check each word against oldest expectation
    always @(posedge clk)
    begin
        answer_t got, want;
        if (rst_n)
        begin
            out_ready <= calm || ($urandom_range(99) >= 6);
            if (out_valid && out_ready)
            begin
                got = '{status, value_out, probe_count, empty_slots, freed_slots};
                if (answer_q.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, got);
                    fail_cnt++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (got.status !== want.status)
                        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    if (got.value_out !== want.value_out)
                        $display("%0t: value_out exp %h got %h", $time, want.value_out,
                                 got.value_out);
                    if (got.probe_count !== want.probe_count)
                        $display("%0t: probe_count exp %0d got %0d", $time,
                                 want.probe_count, got.probe_count);
                    if (got.empty_slots !== want.empty_slots)
                        $display("%0t: empty_slots exp %0d got %0d", $time,
                                 want.empty_slots, got.empty_slots);
                    if (got.freed_slots !== want.freed_slots)
                        $display("%0t: freed_slots exp %0d got %0d", $time,
                                 want.freed_slots, got.freed_slots);
                    if (got !== want)
                        fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt > 20000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        row_t rows[$];
        answer_t a;
        logic [10:0] sizes[$];
        logic [1:0] cmd;
        int r;
        clear_table(SIZE_RESET);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows; typed answers only where obvious after reset
        rows.push_back('{CMD_GET, 32'd5, 32'd0, 1, '{RES_MISS, 0, 0, 1021, 0}});
        rows.push_back('{CMD_SET, 32'h0, 32'd1, 1, '{RES_RSV, 0, 0, 1021, 0}});
        rows.push_back('{CMD_SET, RSV_KEY, 32'd1, 1, '{RES_RSV, 0, 0, 1021, 0}});
        rows.push_back('{CMD_GET, RSV_KEY, 32'd0, 1, '{RES_MISS, 0, 0, 1021, 0}});
        rows.push_back('{CMD_DEL, 32'h0, 32'd0, 1, '{RES_MISS, 0, 0, 1021, 0}});
        rows.push_back('{CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                         '{RES_MISS, 0, 0, 1021, 0}});
        rows.push_back('{CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                         '{RES_INS, 0, 0, 1020, 0}});
        rows.push_back('{CMD_GET, 32'hFFFF_FFFF, 32'd0, 1,
                         '{RES_FOUND, 32'hFFFF_FFFF, 0, 1020, 0}});
        rows.push_back('{CMD_SET, 32'd1, 32'h5555_AAAA, 0, '0});
        rows.push_back('{CMD_SET, 32'd1, 32'hAAAA_5555, 0, '0});
        rows.push_back('{CMD_DEL, 32'hFFFF_FFFF, 32'd0, 0, '0});
        rows.push_back('{CMD_DEL, 32'hFFFF_FFFF, 32'd0, 0, '0});
        rows.push_back('{CMD_SET, 32'h7FFF_FFFF, 32'd0, 0, '0});
        rows.push_back('{CMD_GET, 32'd1, 32'd0, 0, '0});
        rows.push_back('{CMD_DEL, 32'd1, 32'd0, 0, '0});
        foreach (rows[i])
        begin
            a = rows[i].answer;
            send_word(rows[i].command, rows[i].key, rows[i].value);
            if (rows[i].typed && answer_q.size() != 0 && answer_q[$] !== a)
            begin
                $display("%0t: row %0d table exp %h pred %h", $time, i, a, answer_q[$]);
                fail_cnt++;
            end
        end

        // sizes: extremes and out of range; small tables fill and wrap tombstones
        sizes = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd7, 11'd8, 11'd13, 11'd31,
                  11'd1024, 11'd2047, 11'd1021};
        foreach (sizes[p])
        begin
            write_size(sizes[p]);
            calm = (p == 4);
            repeat ((sizes[p] > 100 || sizes[p] < 2) ? 220 : 125)
            begin
                r = $urandom_range(99);
                cmd = (r < 40) ? CMD_SET : (r < 70) ? CMD_GET : (r < 97) ? CMD_DEL : CMD_NOP;
                send_word(cmd, pick_key(), $urandom);
            end
            calm = 1'b0;
        end

        wait_drain();
        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
